/* rtl/core/sabt_pkg.sv */
// shared types and constants of the selective-ack bitmap tracker
`default_nettype none

package sabt_pkg;

	// request kinds carried on the input tuser
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_IDLE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned SACK_W = 64;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // latch request sequence, pending from scheduled flag
		logic clear;      // return tracker state to reset values
		logic step;       // one walk step over a missing sequence
		logic emit;       // load the ack into the output register
		logic clr_sched;  // idle tick sent the scheduled ack
		logic finish;     // record the packet and schedule an ack
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sched;      // ack scheduled
		logic mask_nz;    // received bitmap nonzero
		logic after;      // request sequence lies ahead of next expected
		logic top;        // bitmap top bit set
		logic out_free;   // output register can take an ack this cycle
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/sabt_ctrl.sv */
// controller state machine of the selective-ack bitmap tracker
`default_nettype none

module sabt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_kind,
	output logic               in_ready,
	input  sabt_pkg::sts_t     sts,
	output sabt_pkg::cmd_t     cmd
);
	import sabt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_WALK      = 5'b00010,
		ST_EMIT_WALK = 5'b00100,
		ST_EMIT_TICK = 5'b01000,
		ST_FINISH    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_kind)
						KIND_DATA: begin
							cmd.load = 1'b1;
							state_d  = (sts.sched || sts.mask_nz) ? ST_WALK : ST_FINISH;
						end
						KIND_IDLE: begin
							if (sts.sched) begin
								state_d = ST_EMIT_TICK;
							end
						end
						KIND_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!sts.after) begin
					state_d = ST_FINISH;
				end else if (sts.top) begin
					state_d = ST_EMIT_WALK;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EMIT_WALK: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_EMIT_TICK: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.clr_sched = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sabt_dpath.sv */
// datapath of the selective-ack bitmap tracker: sequence, bitmap, flags, output register
`default_nettype none

module sabt_dpath #(
	parameter int unsigned MASK_BITS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [sabt_pkg::SEQ_W-1:0]        in_seq,
	input  sabt_pkg::cmd_t                         cmd,
	output sabt_pkg::sts_t                         sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [sabt_pkg::SEQ_W-1:0]             out_seq,
	output logic                                   out_present,
	output logic [sabt_pkg::SACK_W-1:0]            out_mask
);
	import sabt_pkg::*;

	logic [SEQ_W-1:0]      next_exp_q;
	logic [MASK_BITS-1:0]  mask_q;
	logic                  sched_q;
	logic                  pending_q;
	logic [SEQ_W-1:0]      seq_q;
	logic                  out_valid_q;
	logic [SEQ_W-1:0]      out_seq_q;
	logic                  out_present_q;
	logic [SACK_W-1:0]     out_mask_q;
	logic [SACK_W-1:0]     mask_ext;
	logic [MASK_BITS-1:0]  mask_shift;

	// bitmap shifted up with the pending ack in bit 0
	assign mask_shift = {mask_q[MASK_BITS-2:0], pending_q};

	// bitmap widened to the ack mask field
	always_comb begin
		mask_ext                = '0;
		mask_ext[MASK_BITS-1:0] = mask_q;
	end

	// status toward the controller
	always_comb begin
		sts.sched    = sched_q;
		sts.mask_nz  = (mask_q != '0);
		sts.after    = ($signed(seq_q) > $signed(next_exp_q));
		sts.top      = mask_q[MASK_BITS-1];
		sts.out_free = !out_valid_q || out_ready;
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_exp_q <= '0;
			mask_q     <= '0;
			sched_q    <= 1'b0;
			pending_q  <= 1'b0;
		end else if (cmd.clear) begin
			next_exp_q <= '0;
			mask_q     <= '0;
			sched_q    <= 1'b0;
			pending_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				pending_q <= sched_q;
			end
			if (cmd.step) begin
				next_exp_q <= next_exp_q + SEQ_W'(1);
				mask_q     <= mask_shift;
				pending_q  <= 1'b0;
			end
			if (cmd.emit) begin
				mask_q    <= '0;
				pending_q <= 1'b0;
			end
			if (cmd.clr_sched) begin
				sched_q <= 1'b0;
			end
			if (cmd.finish) begin
				next_exp_q <= seq_q + SEQ_W'(1);
				mask_q     <= mask_shift;
				pending_q  <= 1'b0;
				sched_q    <= 1'b1;
			end
		end
	end

	// request sequence latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= in_seq;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_seq_q     <= next_exp_q - SEQ_W'(1);
			out_present_q <= (mask_q != '0);
			out_mask_q    <= mask_ext;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_seq     = out_seq_q;
	assign out_present = out_present_q;
	assign out_mask    = out_mask_q;

endmodule

`default_nettype wire

/* rtl/core/selective_ack_bitmap_tracker.sv */
// A data request occupies the block for a load and a finish without a gap walk; with one,
// also a walk step per missing sequence, a check, and an emit if the bitmap top bit is set.
// An idle tick with a scheduled ack leads to an emit; m_tvalid is registered from the emit.
// An emit waits while an earlier ack is held on the output by m_tready low.
// Throughput is set by the one-step-per-cycle gap walk; one request is worked at a time.
// Reset (arst_n low) clears the next expected sequence, the bitmap, the scheduled flag
// and the output register at once; a clear request does the same save the output register.
`default_nettype none

module selective_ack_bitmap_tracker #(
	parameter int unsigned MASK_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] seq_number
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // [31:0] ack_seq, [95:32] sack_bits
	output logic [0:0]       m_tuser    // [0] mask_present
);
	import sabt_pkg::*;

	cmd_t                  cmd;
	sts_t                  sts;
	logic [SEQ_W-1:0]      ack_seq;
	logic                  mask_present;
	logic [SACK_W-1:0]     sack_bits;

	// controller
	sabt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	sabt_dpath #(
		.MASK_BITS (MASK_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_seq      (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_seq     (ack_seq),
		.out_present (mask_present),
		.out_mask    (sack_bits)
	);

	// output packing
	assign m_tdata = {sack_bits, ack_seq};
	assign m_tuser = mask_present;

	// an ack is never loaded over a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("ack emitted over a waiting result");

	// no walk step, emit or finish while a new request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !(cmd.step || cmd.emit || cmd.finish))
		else $error("request accepted while a packet is in work");

	// recording a packet always schedules an ack
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> sts.sched)
		else $error("ack not scheduled after packet");

	// an emitted ack shows on the output in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted ack not presented");

endmodule

`default_nettype wire

/* verif/selective_ack_bitmap_tracker_test.sv */
// testbench for the selective-ack bitmap tracker: stream stimulus, ack prediction and checking
`default_nettype none

module selective_ack_bitmap_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sabt_pkg::*;

	localparam int unsigned MASK_BITS = 64;
	localparam logic [63:0] WIDTH_MASK = (MASK_BITS == 64) ? {64{1'b1}} :
		((64'd1 << MASK_BITS) - 64'd1);
	// kind code the block ignores
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = MASK_BITS + 8;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_REQUESTS = 550;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [31:0] seq_number
	logic [1:0]  s_tuser;    // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;    // [31:0] ack_seq, [95:32] sack_bits
	logic [0:0]  m_tuser;    // [0] mask_present

	int send_gap_pct;
	int stall_pct;
	int quiet_cycles;

	// tracks the receiver state and the acks it must send, in order
	class ack_ledger;
		typedef struct packed {
			logic [31:0] seq;
			logic        present;
			logic [63:0] mask;
		} ack_t;

		logic [31:0] next_exp;
		logic [63:0] rx_mask;
		bit          sched;
		ack_t        awaited[$];
		int          errors;

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			next_exp = '0;
			rx_mask = '0;
			sched = 1'b0;
		endfunction

		// queue an ack from the current state and empty the bitmap
		function void issue_ack();
			ack_t a;
			a.seq = next_exp - 32'd1;
			a.present = (rx_mask != 0);
			a.mask = rx_mask;
			awaited.push_back(a);
			rx_mask = '0;
		endfunction

		// apply one accepted request; returns 0 when the block ignores it
		function bit take_request(logic [1:0] kind, logic [31:0] seq);
			bit pending;
			bit counted;
			counted = 1'b1;
			case (kind)
				KIND_DATA: begin
					pending = sched;
					// gap walk over missing sequences
					if (pending || rx_mask != 0) begin
						for (int g = 0; g <= MASK_BITS + 1; g++) begin
							if (!($signed(seq) > $signed(next_exp)))
								break;
							if (rx_mask[MASK_BITS-1]) begin
								issue_ack();
								pending = 1'b0;
								break;
							end
							next_exp = next_exp + 32'd1;
							rx_mask = (rx_mask << 1) & WIDTH_MASK;
							if (pending) begin
								rx_mask[0] = 1'b1;
								pending = 1'b0;
							end
						end
					end
					// record the packet itself
					next_exp = seq + 32'd1;
					rx_mask = (rx_mask << 1) & WIDTH_MASK;
					if (pending)
						rx_mask[0] = 1'b1;
					sched = 1'b1;
				end
				KIND_IDLE: begin
					if (sched) begin
						issue_ack();
						sched = 1'b0;
					end else begin
						counted = 1'b0;
					end
				end
				KIND_CLEAR: clear_state();
				default: counted = 1'b0;
			endcase
			return counted;
		endfunction

		// compare one delivered ack with the oldest awaited one
		function void match_ack(logic [95:0] data, logic [0:0] user);
			ack_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected ack, expected none, actual seq %h present %b bits %h",
					$time, data[31:0], user[0], data[95:32]);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (data[31:0] !== want.seq) begin
				$display("%0t: ack_seq expected %h actual %h", $time, want.seq, data[31:0]);
				errors++;
			end
			if (user[0] !== want.present) begin
				$display("%0t: mask_present expected %b actual %b", $time, want.present, user[0]);
				errors++;
			end
			if (data[95:32] !== want.mask) begin
				$display("%0t: sack_bits expected %h actual %h", $time, want.mask, data[95:32]);
				errors++;
			end
		endfunction
	endclass

	ack_ledger ledger;

	selective_ack_bitmap_tracker #(
		.MASK_BITS(MASK_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// receiver backpressure, changed on the falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n)
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ack checking and stall watchdog on the rising edge
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				ledger.match_ack(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or ack moved for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// present one request and hold it until accepted; entered and left at a falling edge
	task automatic send_request(input logic [1:0] kind, input logic [31:0] seq,
			output bit counted);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= seq;
		do
			@(posedge clk);
		while (!s_tready);
		counted = ledger.take_request(kind, seq);
		@(negedge clk);
	endtask

	task automatic put(input logic [1:0] kind, input logic [31:0] seq);
		bit counted;
		send_request(kind, seq, counted);
	endtask

	// hold off until every awaited ack has come, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// edge cases: empty idle, ignored kind, in-order run, gap walk, wrap, forced ack, clear
	task automatic run_directed();
		put(KIND_IDLE, 32'h5555_5555);
		put(KIND_UNUSED, 32'hFFFF_FFFF);
		put(KIND_DATA, 32'h0000_0000);
		put(KIND_IDLE, 32'hAAAA_AAAA);
		put(KIND_DATA, 32'h0000_0001);
		put(KIND_DATA, 32'h0000_0002);
		put(KIND_DATA, 32'h0000_0003);
		put(KIND_DATA, 32'h0000_000A);
		put(KIND_IDLE, 32'h0000_0000);
		put(KIND_DATA, 32'h7FFF_FFFF);
		put(KIND_DATA, 32'h8000_0000);
		// far ahead with a nonzero bitmap: walk fills it and forces an ack
		put(KIND_DATA, 32'hFFFF_FFFF);
		put(KIND_IDLE, 32'h0000_0000);
		put(KIND_CLEAR, 32'h1234_5678);
		put(KIND_DATA, 32'hFFFF_FFFB);
		put(KIND_DATA, 32'h0000_0064);
		put(KIND_DATA, 32'h0000_0063);
		put(KIND_IDLE, 32'hFFFF_FFFF);
		put(KIND_IDLE, 32'h0000_0000);
		put(KIND_DATA, 32'h8000_0000);
		put(KIND_DATA, 32'h7FFF_FFFF);
		put(KIND_IDLE, 32'h0000_0000);
		put(KIND_CLEAR, 32'hFFFF_FFFF);
		put(KIND_IDLE, 32'h0000_0000);
	endtask

	// mostly near-in-order traffic with gaps, long in-order bursts, acks, clears and noise
	task automatic run_random(input int want);
		int done;
		int burst;
		int r;
		logic [1:0] kind;
		logic [31:0] seq;
		done = 0;
		burst = 0;
		while (done < want) begin
			kind = KIND_DATA;
			seq = ledger.next_exp;
			if (burst > 0) begin
				burst--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35)
					seq = ledger.next_exp;
				else if (r < 50)
					seq = ledger.next_exp + $urandom_range(1, 8);
				else if (r < 55)
					seq = ledger.next_exp + $urandom_range(MASK_BITS - 4, MASK_BITS + 6);
				else if (r < 60)
					seq = ledger.next_exp - $urandom_range(1, 10);
				else if (r < 63)
					seq = $urandom;
				else if (r < 65)
					burst = $urandom_range(MASK_BITS - 4, MASK_BITS + 6);
				else if (r < 90) begin
					kind = KIND_IDLE;
					seq = $urandom;
				end else if (r < 95) begin
					kind = KIND_CLEAR;
					seq = $urandom;
				end else begin
					kind = KIND_UNUSED;
					seq = $urandom;
				end
			end
			put(kind, seq);
			done++;
		end
	endtask

	// main sequence
	initial begin
		ledger = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_DATA;
		send_gap_pct = 0;
		stall_pct = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		settle();

		run_random(RANDOM_REQUESTS / 4);
		settle();

		send_gap_pct = 77;
		stall_pct = 0;
		run_random(RANDOM_REQUESTS / 4);
		settle();

		send_gap_pct = 0;
		stall_pct = 77;
		run_random(RANDOM_REQUESTS / 4);
		settle();

		send_gap_pct = 19;
		stall_pct = 19;
		run_random(RANDOM_REQUESTS / 4);
		settle();

		if (ledger.awaited.size() != 0) begin
			$display("%0t: %0d acks never arrived", $time, ledger.awaited.size());
			ledger.errors++;
		end
		if (ledger.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

/* selective_ack_bitmap_tracker.f */
rtl/core/sabt_pkg.sv
rtl/core/sabt_ctrl.sv
rtl/core/sabt_dpath.sv
rtl/core/selective_ack_bitmap_tracker.sv
verif/selective_ack_bitmap_tracker_test.sv
